@@ hw/rtl/eti_fa_pkg.sv @@
// ----------------------------------------------------------------------------
// ETI frame assembler package
// Shared types, constants and helper functions of the ETI frame assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package eti_fa_pkg;

  // Largest frame, in bytes, that the assembler accepts.
  localparam int unsigned MaxFrameBytes = 6144;

  // Width of frame byte counts and positions.
  localparam int unsigned TotW = 14;
  localparam int unsigned PosW = 13;
  localparam int unsigned FlW  = 12;

  // Depth of the command queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCID  = 3'd0;
  localparam logic [2:0] CFG_SAD   = 3'd1;
  localparam logic [2:0] CFG_TPL   = 3'd2;
  localparam logic [2:0] CFG_STL   = 3'd3;
  localparam logic [2:0] CFG_MID   = 3'd4;
  localparam logic [2:0] CFG_FICL  = 3'd5;
  localparam logic [2:0] CFG_SYNCE = 3'd6;
  localparam logic [2:0] CFG_SYNCO = 3'd7;

  // Byte slots of one expanded request: header, data byte, trailer.
  localparam logic [4:0] SLOT_ERR    = 5'd0;
  localparam logic [4:0] SLOT_FS0    = 5'd1;
  localparam logic [4:0] SLOT_FS1    = 5'd2;
  localparam logic [4:0] SLOT_FS2    = 5'd3;
  localparam logic [4:0] SLOT_FCT    = 5'd4;
  localparam logic [4:0] SLOT_FICF   = 5'd5;
  localparam logic [4:0] SLOT_FPFL   = 5'd6;
  localparam logic [4:0] SLOT_FLLO   = 5'd7;
  localparam logic [4:0] SLOT_STC0   = 5'd8;
  localparam logic [4:0] SLOT_STC1   = 5'd9;
  localparam logic [4:0] SLOT_STC2   = 5'd10;
  localparam logic [4:0] SLOT_STC3   = 5'd11;
  localparam logic [4:0] SLOT_MNSC0  = 5'd12;
  localparam logic [4:0] SLOT_MNSC1  = 5'd13;
  localparam logic [4:0] SLOT_HCRC0  = 5'd14;
  localparam logic [4:0] SLOT_HCRC1  = 5'd15;
  localparam logic [4:0] SLOT_DATA   = 5'd16;
  localparam logic [4:0] SLOT_MCRC0  = 5'd17;
  localparam logic [4:0] SLOT_MCRC1  = 5'd18;
  localparam logic [4:0] SLOT_TIST3  = 5'd24;

  localparam logic [7:0]  FCT_LAST = 8'd249;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [5:0]  scid;
    logic [9:0]  sad;
    logic [5:0]  tpl;
    logic [9:0]  stl;
    logic [1:0]  mid;
    logic [5:0]  ficl;
    logic [23:0] sync_even;
    logic [23:0] sync_odd;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        err;
    logic        hdr;
    logic        last;
    logic [7:0]  fct;
    logic [2:0]  fp;
    logic [15:0] mst;
  } cmd_t;

  // One byte of CRC-16-CCITT, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Frame length field FL in 32-bit words.
  function automatic logic [FlW-1:0] frame_len(input logic [5:0] ficl, input logic [9:0] stl);
    return FlW'(2) + {6'd0, ficl} + {1'b0, stl, 1'b0};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/eti_fa_if.sv @@
// ----------------------------------------------------------------------------
// ETI frame assembler stream interfaces
// Valid/ready channels for input bytes and output frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface eti_fa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface eti_fa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       config_error;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  output config_error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  input config_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/eti_fa_front.sv @@
// ----------------------------------------------------------------------------
// ETI frame assembler front end
// Classifies each input byte, tracks frame position, MST CRC and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_fa_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  eti_fa_pkg::cfg_t   cfg_i,
  input  wire                logic       in_valid_i,
  input  wire                logic [7:0] in_data_i,
  output logic               in_ready_o,
  input  wire                logic       q_full_i,
  output logic               q_push_o,
  output eti_fa_pkg::cmd_t   q_cmd_o
);
  import eti_fa_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      fct_q, fct_d;
  logic [2:0]      fp_q, fp_d;

  logic [FlW-1:0]  fl;
  logic [TotW-1:0] frame_bytes, total;
  logic            bad, first, last, take;
  logic [15:0]     crc_new;

  assign fl          = frame_len(cfg_i.ficl, cfg_i.stl);
  assign frame_bytes = {fl, 2'b00} + TotW'(16);
  assign total       = {6'd0, cfg_i.ficl, 2'b00} + {1'b0, cfg_i.stl, 3'b000};
  assign bad         = (cfg_i.stl == '0) || (frame_bytes > TotW'(MaxFrameBytes));
  assign first       = (pos_q == '0);
  assign last        = ({1'b0, pos_q} + TotW'(1)) >= total;
  assign crc_new     = crc_byte(first ? CRC_INIT : crc_q, in_data_i);

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign q_push_o   = take;

  always_comb begin
    q_cmd_o.data = in_data_i;
    q_cmd_o.err  = bad;
    q_cmd_o.hdr  = first;
    q_cmd_o.last = last;
    q_cmd_o.fct  = fct_q;
    q_cmd_o.fp   = fp_q;
    q_cmd_o.mst  = crc_new;
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    fct_d = fct_q;
    fp_d  = fp_q;
    if (take && !bad) begin
      if (last) begin
        pos_d = '0;
        crc_d = CRC_INIT;
        fct_d = (fct_q >= FCT_LAST) ? 8'd0 : fct_q + 8'd1;
        fp_d  = fp_q + 3'd1;
      end else begin
        pos_d = pos_q + PosW'(1);
        crc_d = crc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
      fct_q <= '0;
      fp_q  <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      fct_q <= fct_d;
      fp_q  <= fp_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/eti_fa_queue.sv @@
// ----------------------------------------------------------------------------
// ETI frame assembler command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_fa_queue (
  input  wire               logic clk_i,
  input  wire               logic rst_ni,
  input  wire               logic push_i,
  input  eti_fa_pkg::cmd_t  push_cmd_i,
  input  wire               logic pop_i,
  output eti_fa_pkg::cmd_t  head_o,
  output logic              empty_o,
  output logic              full_o
);
  import eti_fa_pkg::*;

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAw'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAw+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAw+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/eti_fa_back.sv @@
// ----------------------------------------------------------------------------
// ETI frame assembler back end
// Expands each queued request into header, data and trailer bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_fa_back (
  input  wire               logic clk_i,
  input  wire               logic rst_ni,
  input  eti_fa_pkg::cfg_t  cfg_i,
  input  eti_fa_pkg::cmd_t  cmd_i,
  input  wire               logic q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire               logic out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              frame_end_o,
  output logic              config_error_o
);
  import eti_fa_pkg::*;

  logic [4:0]     slot_q, slot_d, slot;
  logic           busy_q, busy_d;
  logic [15:0]    hcrc_q, hcrc_d;
  logic           vld_q, vld_d;
  logic [7:0]     byte_q, byte_d;
  logic           rl_q, rl_d, fe_q, fe_d, ce_q, ce_d;

  logic           adv;
  logic [FlW-1:0] fl;
  logic [23:0]    fs;
  logic [7:0]     cur;

  assign fl   = frame_len(cfg_i.ficl, cfg_i.stl);
  assign fs   = cmd_i.fct[0] ? cfg_i.sync_odd : cfg_i.sync_even;
  assign slot = busy_q ? slot_q : (cmd_i.hdr ? SLOT_ERR : SLOT_DATA);
  assign adv  = !q_empty_i && (!vld_q || out_ready_i);

  // Byte that the current slot puts out.
  always_comb begin
    unique case (slot) inside
      SLOT_FS0:               cur = fs[23:16];
      SLOT_FS1:               cur = fs[15:8];
      SLOT_FS2:               cur = fs[7:0];
      SLOT_FCT:               cur = cmd_i.fct;
      SLOT_FICF:              cur = 8'h81;
      SLOT_FPFL:              cur = {cmd_i.fp, cfg_i.mid, fl[10:8]};
      SLOT_FLLO:              cur = fl[7:0];
      SLOT_STC0:              cur = {cfg_i.scid, cfg_i.sad[9:8]};
      SLOT_STC1:              cur = cfg_i.sad[7:0];
      SLOT_STC2:              cur = {cfg_i.tpl, cfg_i.stl[9:8]};
      SLOT_STC3:              cur = cfg_i.stl[7:0];
      SLOT_MNSC0, SLOT_MNSC1: cur = 8'h00;
      SLOT_HCRC0:             cur = ~hcrc_q[15:8];
      SLOT_HCRC1:             cur = ~hcrc_q[7:0];
      SLOT_DATA:              cur = cmd_i.data;
      SLOT_MCRC0:             cur = ~cmd_i.mst[15:8];
      SLOT_MCRC1:             cur = ~cmd_i.mst[7:0];
      default:                cur = 8'hFF;
    endcase
  end

  always_comb begin
    slot_d  = slot_q;
    busy_d  = busy_q;
    hcrc_d  = hcrc_q;
    vld_d   = vld_q && !out_ready_i;
    byte_d  = byte_q;
    rl_d    = rl_q;
    fe_d    = fe_q;
    ce_d    = ce_q;
    q_pop_o = 1'b0;
    if (adv) begin
      vld_d = 1'b1;
      if (cmd_i.err) begin
        byte_d  = 8'h00;
        rl_d    = 1'b1;
        fe_d    = 1'b0;
        ce_d    = 1'b1;
        q_pop_o = 1'b1;
        busy_d  = 1'b0;
      end else begin
        byte_d = cur;
        ce_d   = 1'b0;
        fe_d   = (slot == SLOT_TIST3);
        rl_d   = (slot == SLOT_TIST3) || (slot == SLOT_DATA && !cmd_i.last);
        if (slot >= SLOT_FCT && slot <= SLOT_MNSC1) begin
          hcrc_d = crc_byte((slot == SLOT_FCT) ? CRC_INIT : hcrc_q, cur);
        end
        if (rl_d) begin
          q_pop_o = 1'b1;
          busy_d  = 1'b0;
        end else begin
          slot_d = slot + 5'd1;
          busy_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      slot_q <= slot_d;
      busy_q <= busy_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hcrc_q <= hcrc_d;
    byte_q <= byte_d;
    rl_q   <= rl_d;
    fe_q   <= fe_d;
    ce_q   <= ce_d;
  end

  assign out_valid_o    = vld_q;
  assign out_byte_o     = byte_q;
  assign run_last_o     = rl_q;
  assign frame_end_o    = fe_q;
  assign config_error_o = ce_q;

endmodule

`default_nettype wire

@@ hw/rtl/eti_frame_assembler_core.sv @@
// ----------------------------------------------------------------------------
// ETI(NI) frame assembler core
// Builds single-subchannel ETI(NI) frames from a stream of FIC and payload bytes.
// ----------------------------------------------------------------------------
// The core takes one input byte per request on in_i: first the FIC bytes of a
// frame (fic_words * 4), then its subchannel payload (stream_length_units * 8).
// The first byte of a frame produces the 16 header bytes (ERR, FSYNC, FC, STC,
// MNSC, header CRC) followed by the byte itself; the last payload byte is
// followed by the MST CRC, RFU and TIST, the final TIST byte carrying
// frame_end. Every other byte passes straight through. A zero stream length
// or a frame above 6144 bytes makes each input produce one config_error result
// and leaves the frame state untouched. The front end accepts one byte per
// clock while a four-entry request queue has room; the back end sequencer
// emits one output byte per clock while the sink is ready, so an input yields
// 1, 9 or 17 output bytes; the input stalls only when the queue is full, after
// a header or trailer burst or a sink stall. Inputs are queued, then registered
// as output bytes. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_data_i and must only change while no frame bytes are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_frame_assembler_core (
  input  wire         logic        clk_i,
  input  wire         logic        rst_ni,
  input  wire         logic        cfg_we_i,
  input  wire         logic [2:0]  cfg_idx_i,
  input  wire         logic [23:0] cfg_data_i,
  eti_fa_in_if.sink   in_i,
  eti_fa_out_if.source out_o
);
  import eti_fa_pkg::*;

  // Configuration register file. Fields are truncated to their own widths.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCID:  cfg_d.scid      = cfg_data_i[5:0];
        CFG_SAD:   cfg_d.sad       = cfg_data_i[9:0];
        CFG_TPL:   cfg_d.tpl       = cfg_data_i[5:0];
        CFG_STL:   cfg_d.stl       = cfg_data_i[9:0];
        CFG_MID:   cfg_d.mid       = cfg_data_i[1:0];
        CFG_FICL:  cfg_d.ficl      = cfg_data_i[5:0];
        CFG_SYNCE: cfg_d.sync_even = cfg_data_i;
        CFG_SYNCO: cfg_d.sync_odd  = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scid      <= 6'd0;
      cfg_q.sad       <= 10'd0;
      cfg_q.tpl       <= 6'd0;
      cfg_q.stl       <= 10'd0;
      cfg_q.mid       <= 2'd1;
      cfg_q.ficl      <= 6'd24;
      cfg_q.sync_even <= 24'h073AB6;
      cfg_q.sync_odd  <= 24'hF8C549;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Requests flow front end -> queue -> back end.
  cmd_t push_cmd, head_cmd;
  logic push, pop, q_empty, q_full;

  eti_fa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  eti_fa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // The back end's output register separates the queue from the sink, so while
  // a finished result waits, the front end takes bytes until the queue is full.
  eti_fa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (head_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_byte_o     (out_o.out_byte),
    .run_last_o     (out_o.run_last),
    .frame_end_o    (out_o.frame_end),
    .config_error_o (out_o.config_error)
  );

endmodule

`default_nettype wire
